### hw/rtl/iss_pkg.sv
// Package: types, constants and codes of the indexed sequence store
`timescale 1ns / 1ps
`default_nettype none
package iss_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [DATA_W-1:0] ERR_VALUE = '1;

    typedef enum logic [2:0] {
        CMD_PRINT     = 3'd0,
        CMD_APPEND    = 3'd1,
        CMD_DELETE    = 3'd2,
        CMD_PRINT_REV = 3'd3,
        CMD_SUM       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_COMPACT
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROT_L,
        OP_ROT_R,
        OP_WRITE,
        OP_COMPACT
    } t_cell_op;

    typedef struct packed {
        t_cmd              cmd;
        logic signed [31:0] item_value;
        logic [POS_W-1:0]  position;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               is_empty;
        logic               is_error;
        logic               last_of_run;
    } t_result;

    typedef struct packed {
        t_cell_op          op;
        logic [CNT_W-1:0]  count;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] wdata;
    } t_cell_ctl;

endpackage
`default_nettype wire

### hw/rtl/indexed_sequence_store_top.sv
// Top level of the indexed sequence store: ring of entry cells and its sequencer
//
//  channel  ports                       transfer
//  command  start, busy, i_item         start high while busy low
//  result   o_valid, o_result           o_valid high, one cycle, no stall
//
//  Print, print reverse (when the store is not empty) and sum walk the whole
//  ring; append writes the new entry, then walks it as a print; delete walks
//  it, then compacts. Error, empty-print and unused commands end without a walk;
//  unused commands give no result. Each result is registered before it appears.
//  Reset clears the count. Results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module indexed_sequence_store_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire iss_pkg::t_in_item i_item,
    output logic                   o_valid,
    output iss_pkg::t_result       o_result
);
    import iss_pkg::*;

    logic [DATA_W-1:0] cell_val [CAPACITY];
    t_cell_ctl         cell_ctl;
    logic              accept;

    assign accept = start && !busy;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            iss_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl),
                .i_index (IDX_W'(gi)),
                .i_next  (cell_val[(gi + 1) % CAPACITY]),
                .i_prev  (cell_val[(gi + CAPACITY - 1) % CAPACITY]),
                .o_value (cell_val[gi])
            );
        end
    endgenerate

    iss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_head   (cell_val[0]),
        .i_tail   (cell_val[CAPACITY-1]),
        .o_ctl    (cell_ctl),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.is_error |-> o_result.last_of_run)
        else $error("error result not marked last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.is_empty |->
            o_result.result_value == 0 && !o_result.is_error && o_result.last_of_run)
        else $error("empty result malformed");

    a_busy_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

endmodule
`default_nettype wire

### hw/rtl/iss_cell.sv
// One storage cell of the entry ring: holds one entry and takes a neighbor's value or the write data
`timescale 1ns / 1ps
`default_nettype none
module iss_cell (
    input  wire logic                      i_clk,
    input  wire iss_pkg::t_cell_ctl        i_ctl,
    input  wire logic [iss_pkg::IDX_W-1:0] i_index,
    input  wire logic [iss_pkg::DATA_W-1:0] i_next,
    input  wire logic [iss_pkg::DATA_W-1:0] i_prev,
    output logic [iss_pkg::DATA_W-1:0]      o_value
);
    import iss_pkg::*;

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            OP_ROT_L: begin
                n_value = i_next;
            end
            OP_ROT_R: begin
                n_value = i_prev;
            end
            OP_WRITE: begin
                if (CNT_W'(i_index) == i_ctl.count) begin
                    n_value = i_ctl.wdata;
                end
            end
            OP_COMPACT: begin
                if (CMP_W'(i_index) >= CMP_W'(i_ctl.pos)) begin
                    n_value = i_next;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

### hw/rtl/iss_ctrl.sv
// Sequencer: command decode, ring walk counter, sum, count and result register
`timescale 1ns / 1ps
`default_nettype none
module iss_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire iss_pkg::t_in_item          i_item,
    input  wire logic [iss_pkg::DATA_W-1:0] i_head,
    input  wire logic [iss_pkg::DATA_W-1:0] i_tail,
    output iss_pkg::t_cell_ctl              o_ctl,
    output logic                            o_busy,
    output logic                            o_valid,
    output iss_pkg::t_result                o_result
);
    import iss_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_mode, n_mode;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_step, n_step;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_del, n_del;
    logic              r_valid, n_valid;
    t_result           r_out, n_out;

    logic in_range;
    logic step_end;
    logic is_full;
    logic del_bad;
    logic rev_emit;

    assign in_range = CNT_W'(r_step) < r_cnt;
    assign step_end = r_step == IDX_W'(CAPACITY - 1);
    assign is_full  = r_cnt == CNT_W'(CAPACITY);
    assign del_bad  = CMP_W'(i_item.position) >= CMP_W'(r_cnt);
    assign rev_emit = ((CNT_W+1)'(r_step) + (CNT_W+1)'(r_cnt)) >= (CNT_W+1)'(CAPACITY);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    case (i_item.cmd)
                        CMD_PRINT, CMD_PRINT_REV: begin
                            if (r_cnt != '0) begin
                                n_state = ST_WALK;
                            end
                        end
                        CMD_APPEND: begin
                            if (!is_full) begin
                                n_state = ST_WALK;
                            end
                        end
                        CMD_DELETE: begin
                            if (!del_bad) begin
                                n_state = ST_WALK;
                            end
                        end
                        CMD_SUM: begin
                            n_state = ST_WALK;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (step_end) begin
                    n_state = (r_mode == CMD_DELETE) ? ST_COMPACT : ST_IDLE;
                end
            end
            ST_COMPACT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_del   = r_del;
        n_valid = 1'b0;
        n_out   = '0;
        o_ctl.op    = OP_HOLD;
        o_ctl.count = r_cnt;
        o_ctl.pos   = r_pos;
        o_ctl.wdata = i_item.item_value;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                n_acc  = '0;
                if (i_accept) begin
                    n_mode = i_item.cmd;
                    n_pos  = i_item.position;
                    case (i_item.cmd)
                        CMD_PRINT, CMD_PRINT_REV: begin
                            if (r_cnt == '0) begin
                                n_valid = 1'b1;
                                n_out.is_empty    = 1'b1;
                                n_out.last_of_run = 1'b1;
                            end
                        end
                        CMD_APPEND: begin
                            n_mode = CMD_PRINT;
                            if (is_full) begin
                                n_valid = 1'b1;
                                n_out.result_value = ERR_VALUE;
                                n_out.is_error     = 1'b1;
                                n_out.last_of_run  = 1'b1;
                            end else begin
                                o_ctl.op = OP_WRITE;
                                n_cnt    = r_cnt + CNT_W'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (del_bad) begin
                                n_valid = 1'b1;
                                n_out.result_value = ERR_VALUE;
                                n_out.is_error     = 1'b1;
                                n_out.last_of_run  = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                n_step   = r_step + IDX_W'(1);
                o_ctl.op = (r_mode == CMD_PRINT_REV) ? OP_ROT_R : OP_ROT_L;
                case (r_mode)
                    CMD_PRINT: begin
                        if (in_range) begin
                            n_valid = 1'b1;
                            n_out.result_value = i_head;
                            n_out.last_of_run  = (CNT_W'(r_step) + CNT_W'(1)) == r_cnt;
                        end
                    end
                    CMD_PRINT_REV: begin
                        if (rev_emit) begin
                            n_valid = 1'b1;
                            n_out.result_value = i_tail;
                            n_out.last_of_run  = step_end;
                        end
                    end
                    CMD_SUM: begin
                        if (in_range) begin
                            n_acc = r_acc + i_head;
                        end
                        if (step_end) begin
                            n_valid = 1'b1;
                            n_out.result_value = n_acc;
                            n_out.last_of_run  = 1'b1;
                        end
                    end
                    CMD_DELETE: begin
                        if (CMP_W'(r_step) == CMP_W'(r_pos)) begin
                            n_del = i_head;
                        end
                    end
                    default: begin
                        n_valid = 1'b0;
                    end
                endcase
            end
            ST_COMPACT: begin
                o_ctl.op = OP_COMPACT;
                n_cnt    = r_cnt - CNT_W'(1);
                n_valid  = 1'b1;
                n_out.result_value = r_del;
                n_out.last_of_run  = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_step <= n_step;
        r_pos  <= n_pos;
        r_acc  <= n_acc;
        r_del  <= n_del;
        r_out  <= n_out;
    end

    assign o_busy   = r_state != ST_IDLE;
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

### tb/sv/sequence_checker.sv
// Checker: predicts the store's results from accepted commands and compares them in order
`timescale 1ns / 1ps
module sequence_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire iss_pkg::t_in_item i_item,
    input  wire logic              i_valid,
    input  wire iss_pkg::t_result  i_result,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);
    import iss_pkg::*;

    logic signed [DATA_W-1:0] stored [CAPACITY];
    int                       stored_count;
    t_result                  expected_q [$];

    initial begin
        stored_count = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic void push_result(logic signed [DATA_W-1:0] value, logic empty,
                                        logic error, logic last);
        t_result r;
        r.result_value = value;
        r.is_empty     = empty;
        r.is_error     = error;
        r.last_of_run  = last;
        expected_q.push_back(r);
    endfunction

    function automatic void list_sequence(bit reverse);
        int idx;
        if (stored_count == 0) begin
            push_result('0, 1'b1, 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < stored_count; i++) begin
            idx = reverse ? stored_count - 1 - i : i;
            push_result(stored[idx], 1'b0, 1'b0, (i == stored_count - 1));
        end
    endfunction

    function automatic void predict_command(t_in_item item);
        logic signed [DATA_W-1:0] total;
        int                       pos;
        pos = int'(item.position);
        case (item.cmd)
            CMD_PRINT:     list_sequence(1'b0);
            CMD_PRINT_REV: list_sequence(1'b1);
            CMD_APPEND: begin
                if (stored_count >= CAPACITY) begin
                    push_result(ERR_VALUE, 1'b0, 1'b1, 1'b1);
                end else begin
                    stored[stored_count] = item.item_value;
                    stored_count++;
                    list_sequence(1'b0);
                end
            end
            CMD_DELETE: begin
                if (pos >= stored_count) begin
                    push_result(ERR_VALUE, 1'b0, 1'b1, 1'b1);
                end else begin
                    push_result(stored[pos], 1'b0, 1'b0, 1'b1);
                    for (int i = pos; i + 1 < stored_count; i++) begin
                        stored[i] = stored[i + 1];
                    end
                    stored_count--;
                end
            end
            CMD_SUM: begin
                total = '0;
                for (int i = 0; i < stored_count; i++) begin
                    total = total + stored[i];
                end
                push_result(total, 1'b0, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result exp_result;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                predict_command(i_item);
            end
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result value=%0d empty=%0b error=%0b last=%0b",
                             $time, i_result.result_value, i_result.is_empty,
                             i_result.is_error, i_result.last_of_run);
                    o_fail_count++;
                end else begin
                    exp_result = expected_q.pop_front();
                    o_checked++;
                    if (i_result !== exp_result) begin
                        $display({"%0t: result differs, expected value=%0d empty=%0b ",
                                  "error=%0b last=%0b, actual value=%0d empty=%0b ",
                                  "error=%0b last=%0b"},
                                 $time, exp_result.result_value, exp_result.is_empty,
                                 exp_result.is_error, exp_result.last_of_run,
                                 i_result.result_value, i_result.is_empty,
                                 i_result.is_error, i_result.last_of_run);
                        o_fail_count++;
                    end
                end
            end
            o_pending = expected_q.size();
        end
    end

endmodule

### tb/sv/testbench.sv
// Testbench top: drives commands into the indexed sequence store and gives the verdict
`timescale 1ns / 1ps
module testbench;
    import iss_pkg::*;

    localparam int         LIMIT_CYCLES    = 200000;
    localparam int         SETTLE_CYCLES   = 2 * CAPACITY + 8;
    localparam int         RANDOM_ITEMS    = 135;
    localparam int         IDLE_PERCENT    = 19;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_in_item i_item  = '0;
    logic     busy;
    logic     o_valid;
    t_result  o_result;

    int fail_count;
    int pending;
    int checked;
    int cycles       = 0;
    int shadow_count = 0;
    int peak_count   = 0;
    int sent_count   = 0;
    int full_appends = 0;
    bit idle_enabled = 1'b1;

    indexed_sequence_store_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    sequence_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results waiting", cycles, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic [2:0] code, logic signed [DATA_W-1:0] value,
                                           logic [POS_W-1:0] pos);
        t_in_item item;
        item.cmd        = t_cmd'(code);
        item.item_value = value;
        item.position   = pos;
        return item;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // fill favors appends, drain favors deletes, mixed leans on appends and deletes
    function automatic logic [2:0] pick_code(int phase);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            0: begin
                if (roll < 80) return CMD_APPEND;
                if (roll < 85) return CMD_DELETE;
                if (roll < 90) return CMD_PRINT;
                if (roll < 93) return CMD_PRINT_REV;
                if (roll < 97) return CMD_SUM;
            end
            1: begin
                if (roll < 55) return CMD_DELETE;
                if (roll < 65) return CMD_APPEND;
                if (roll < 75) return CMD_PRINT;
                if (roll < 85) return CMD_PRINT_REV;
                if (roll < 95) return CMD_SUM;
            end
            default: begin
                if (roll < 30) return CMD_APPEND;
                if (roll < 55) return CMD_DELETE;
                if (roll < 70) return CMD_PRINT;
                if (roll < 80) return CMD_PRINT_REV;
                if (roll < 93) return CMD_SUM;
            end
        endcase
        return 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    endfunction

    task automatic send_item(input t_in_item item);
        while (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        sent_count++;
        case (item.cmd)
            CMD_APPEND: begin
                if (shadow_count < CAPACITY) begin
                    shadow_count++;
                end else begin
                    full_appends++;
                end
            end
            CMD_DELETE: begin
                if (int'(item.position) < shadow_count) shadow_count--;
            end
            default: ;
        endcase
        if (shadow_count > peak_count) peak_count = shadow_count;
    endtask

    initial begin
        int               active_items;
        int               phase;
        logic [2:0]       code;
        logic [POS_W-1:0] pos;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(make_item(CMD_PRINT, pick_value(), 5'd0));
        send_item(make_item(CMD_PRINT_REV, pick_value(), 5'd31));
        send_item(make_item(CMD_SUM, pick_value(), 5'd0));
        send_item(make_item(CMD_DELETE, pick_value(), 5'd0));
        send_item(make_item(CMD_SPARE_FIRST, pick_value(), 5'd0));
        send_item(make_item(CMD_APPEND, VALUE_MAX, 5'd0));
        send_item(make_item(CMD_APPEND, VALUE_MIN, 5'd31));
        send_item(make_item(CMD_APPEND, '0, 5'd0));
        send_item(make_item(CMD_APPEND, -1, 5'd0));
        send_item(make_item(CMD_PRINT, '0, 5'd0));
        send_item(make_item(CMD_PRINT_REV, '0, 5'd0));
        send_item(make_item(CMD_SUM, '0, 5'd0));
        send_item(make_item(CMD_DELETE, '0, 5'd31));
        send_item(make_item(CMD_DELETE, '0, 5'd4));
        send_item(make_item(CMD_DELETE, '0, 5'd1));
        send_item(make_item(CMD_DELETE, '0, 5'd2));
        send_item(make_item(CMD_DELETE, '0, 5'd0));
        send_item(make_item(CMD_SPARE_MID, -1, 5'd31));
        send_item(make_item(CMD_SPARE_LAST, VALUE_MIN, 5'd1));
        send_item(make_item(CMD_PRINT, '0, 5'd0));
        send_item(make_item(CMD_DELETE, '0, 5'd0));
        send_item(make_item(CMD_SUM, '0, 5'd0));
        send_item(make_item(CMD_PRINT_REV, '0, 5'd0));

        active_items = 0;
        while (active_items < RANDOM_ITEMS) begin
            phase = (active_items < 45)  ? 0 :
                    (active_items < 80)  ? 1 :
                    (active_items < 112) ? 0 : 2;
            idle_enabled = !(active_items >= 45 && active_items < 80);
            code = pick_code(phase);
            pos  = POS_W'($urandom_range(0, 31));
            if (code == CMD_DELETE && shadow_count > 0 && $urandom_range(0, 99) < 85) begin
                pos = POS_W'($urandom_range(0, shadow_count - 1));
            end
            send_item(make_item(code, pick_value(), pos));
            if (code < CMD_SPARE_FIRST) active_items++;
        end
        start <= 1'b0;

        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d commands; store filled up to %0d of %0d, %0d appends hit a full store",
                 sent_count, peak_count, CAPACITY, full_appends);
        $display("Compared %0d results: %0d wrong, %0d never arrived",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/iss_pkg.sv
hw/rtl/iss_cell.sv
hw/rtl/iss_ctrl.sv
hw/rtl/indexed_sequence_store_top.sv
tb/sv/sequence_checker.sv
tb/sv/testbench.sv
